// ----- hdl/pe_pkg.sv -----
package pe_pkg;

  localparam int unsigned KeyBits = 31;
  localparam int unsigned SqBits  = 2 * KeyBits;

  typedef logic [KeyBits-1:0] key_t;
  typedef logic [SqBits-1:0]  sq_t;

  // control from the sequencer to the modular multiplier
  typedef struct packed {
    logic start;
    sq_t  a;
    sq_t  b;
  } mm_req_t;

  typedef struct packed {
    logic done;
    sq_t  p;
  } mm_rsp_t;

endpackage

// ----- hdl/paillier_encrypt.sv -----
// Paillier encryption, g = n+1: ciphertext_o = (n*m+1) * r^n mod n^2 (zero for n < 2).
// Raise start while busy is low with plaintext_i and random_r_i; busy
// rises the next cycle. Modular multiplies run on one shared shift-and-add
// unit; r^n takes up to 62 multiplies by square-and-multiply over the bits
// of n, plus setup steps. The result appears on ciphertext_o for exactly
// one cycle with done_o high; the receiver cannot stall it, so capture it
// then. Write n on the cfg channel only while busy is low; cfg_ready_o is
// high when idle. n^2 is rebuilt on the shared unit after each write.
module paillier_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] plaintext_i,
  input  logic [30:0] random_r_i,
  output logic        done_o,
  output logic [61:0] ciphertext_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_data_i
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StNsq   = 4'd1; // n*n with a huge modulus
  localparam logic [3:0] StNm    = 4'd2; // n*m mod n^2
  localparam logic [3:0] StRmod  = 4'd3; // r*1 mod n^2
  localparam logic [3:0] StSq    = 4'd4; // acc*acc
  localparam logic [3:0] StMul   = 4'd5; // acc*base
  localparam logic [3:0] StFin   = 4'd6; // nude*obf
  localparam logic [3:0] StOut   = 4'd7;
  localparam logic [3:0] StWait  = 4'd8;

  localparam int unsigned Kb = pe_pkg::KeyBits;
  localparam int unsigned Sb = pe_pkg::SqBits;
  localparam int unsigned EBits = $clog2(Kb + 1);

  logic [3:0]        st_q, st_d, nxt_q, nxt_d;
  pe_pkg::key_t      n_q, n_d;
  pe_pkg::sq_t       nsq_q, nsq_d, acc_q, acc_d, base_q, base_d, nude_q, nude_d;
  logic [EBits-1:0]  bit_q, bit_d;
  pe_pkg::mm_req_t   req;
  pe_pkg::mm_rsp_t   rsp;
  pe_pkg::sq_t       mod_sel;
  logic [Sb:0]       nude_raw;

  pe_modmul u_mm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .mod_i (mod_sel),
    .req_i (req),
    .rsp_o (rsp)
  );

  // n^2 computed with modulus all-ones: products of 31-bit values never reach it
  assign mod_sel = (st_q == StWait && nxt_q == StNsq) ? '1 : nsq_q;
  // n*m reduced, then +1 with one wrap (n*m mod n^2 < n^2)
  assign nude_raw = {1'b0, rsp.p} + 1'b1;

  always_comb begin
    st_d    = st_q;
    nxt_d   = nxt_q;
    n_d     = n_q;
    nsq_d   = nsq_q;
    acc_d   = acc_q;
    base_d  = base_q;
    nude_d  = nude_q;
    bit_d   = bit_q;
    req     = '0;
    unique case (st_q)
      StIdle: begin
        if (cfg_valid_i) begin
          n_d       = cfg_data_i;
          req.start = 1'b1;
          req.a     = Sb'(cfg_data_i);
          req.b     = Sb'(cfg_data_i);
          st_d      = StWait;
          nxt_d     = StNsq;
        end else if (start) begin
          if (n_q < Kb'(2)) begin
            acc_d = '0;
            st_d  = StOut;
          end else begin
            // the negative-range re-encoding yields n*m+1 as well
            req.start = 1'b1;
            req.a     = Sb'(n_q);
            req.b     = Sb'(plaintext_i);
            st_d      = StWait;
            nxt_d     = StNm;
            base_d    = Sb'(random_r_i);
          end
        end
      end
      StWait: begin
        if (rsp.done) st_d = nxt_q;
      end
      StNsq: begin
        nsq_d = rsp.p;
        st_d  = StIdle;
      end
      StNm: begin
        nude_d    = (nude_raw >= {1'b0, nsq_q}) ? Sb'(nude_raw - {1'b0, nsq_q})
                                                : nude_raw[Sb-1:0];
        // r rides on the multiplier operand so that r >= n^2 is reduced too
        req.start = 1'b1;
        req.a     = Sb'(1);
        req.b     = base_q;
        st_d      = StWait;
        nxt_d     = StRmod;
      end
      StRmod: begin
        base_d  = rsp.p;
        acc_d   = Sb'(1);
        bit_d   = EBits'(Kb - 1);
        // start squaring the (trivial) accumulator at the top bit
        req.start = 1'b1;
        req.a     = Sb'(1);
        req.b     = Sb'(1);
        st_d      = StWait;
        nxt_d     = StSq;
      end
      StSq: begin
        // rsp.p = acc^2; multiply in base if this bit of n is set
        acc_d = rsp.p;
        if (n_q[bit_q[$clog2(Kb)-1:0]]) begin
          req.start = 1'b1;
          req.a     = rsp.p;
          req.b     = base_q;
          st_d      = StWait;
          nxt_d     = StMul;
        end else if (bit_q == '0) begin
          req.start = 1'b1;
          req.a     = nude_q;
          req.b     = rsp.p;
          st_d      = StWait;
          nxt_d     = StFin;
        end else begin
          bit_d     = bit_q - 1'b1;
          req.start = 1'b1;
          req.a     = rsp.p;
          req.b     = rsp.p;
          st_d      = StWait;
          nxt_d     = StSq;
        end
      end
      StMul: begin
        acc_d     = rsp.p;
        req.start = 1'b1;
        st_d      = StWait;
        if (bit_q == '0) begin
          req.a = nude_q;
          req.b = rsp.p;
          nxt_d = StFin;
        end else begin
          bit_d = bit_q - 1'b1;
          req.a = rsp.p;
          req.b = rsp.p;
          nxt_d = StSq;
        end
      end
      StFin: begin
        acc_d = rsp.p;
        st_d  = StOut;
      end
      StOut: begin
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      nxt_q   <= StIdle;
      n_q     <= Kb'(3);
      nsq_q   <= Sb'(9);
    end else begin
      st_q    <= st_d;
      nxt_q   <= nxt_d;
      n_q     <= n_d;
      nsq_q   <= nsq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    nude_q <= nude_d;
    bit_q  <= bit_d;
  end

  assign busy         = (st_q != StIdle) || cfg_valid_i;
  assign cfg_ready_o  = (st_q == StIdle);
  assign done_o       = (st_q == StOut);
  assign ciphertext_o = acc_q;

  // hold the modulus while an item is in flight
  a_n_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle && st_q != StNsq && !(st_q == StWait && nxt_q == StNsq))
      |=> $stable(n_q)) else $error("modulus changed mid item");
  // a result strobe is always followed by idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> st_q == StIdle) else $error("no idle after result");
  // the multiplier never reports done outside a wait
  a_mm_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> st_q == StWait) else $error("stray multiplier done");
endmodule

// ----- hdl/pe_modmul.sv -----
// Shift-and-add modular multiply, one bit of b per cycle, MSB first.
// Each step: acc = 2*acc mod m, then add a mod m if the current bit of b is set.
module pe_modmul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pe_pkg::sq_t      mod_i,
  input  pe_pkg::mm_req_t  req_i,
  output pe_pkg::mm_rsp_t  rsp_o
);
  localparam int unsigned CntBits = $clog2(pe_pkg::SqBits + 1);

  logic               busy_q, busy_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  pe_pkg::sq_t        a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic               done_q, done_d;
  logic [pe_pkg::SqBits:0] dbl, dbl_r, add, add_r;

  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, mod_i}) ? dbl - {1'b0, mod_i} : dbl;
    add   = dbl_r + {1'b0, a_q};
    add_r = (add >= {1'b0, mod_i}) ? add - {1'b0, mod_i} : add;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        a_d    = req_i.a;
        b_d    = req_i.b;
        acc_d  = '0;
        cnt_d  = CntBits'(pe_pkg::SqBits);
      end
    end else begin
      acc_d = b_q[pe_pkg::SqBits-1] ? add_r[pe_pkg::SqBits-1:0]
                                    : dbl_r[pe_pkg::SqBits-1:0];
      b_d   = {b_q[pe_pkg::SqBits-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;
endmodule

// ----- test/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // limit on cycles with no accepted request, key write or ciphertext
  localparam int unsigned  StallLimit = 40000;
  localparam pe_pkg::key_t KeyMax     = '1;

  typedef struct {
    pe_pkg::key_t plaintext;
    pe_pkg::key_t random_r;
  } enc_req_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  pe_pkg::key_t plaintext_i = '0;
  pe_pkg::key_t random_r_i = '0;
  logic         done_o;
  pe_pkg::sq_t  ciphertext_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  pe_pkg::key_t cfg_data_i = '0;

  enc_req_t     enc_queue[$];
  pe_pkg::sq_t  cipher_queue[$];

  // model copy of the key
  pe_pkg::key_t modulus_n;
  logic [63:0]  modulus_sq;

  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned ciphers_seen = 0;
  int unsigned key_writes = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  paillier_encrypt u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .plaintext_i  (plaintext_i),
    .random_r_i   (random_r_i),
    .done_o       (done_o),
    .ciphertext_o (ciphertext_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // (x * y) mod m at full width; x, y < 2^62 fit a 124-bit product
  function automatic logic [63:0] mul_reduce(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] prod;
    prod = 128'(x) * 128'(y);
    return 64'(prod % 128'(m));
  endfunction

  // (n*m + 1) * r^n mod n^2. The negative-range encoding inverts to n*m + 1
  // as well, so both ranges land on the same expression.
  function automatic pe_pkg::sq_t encrypt_expected(pe_pkg::key_t m, pe_pkg::key_t r);
    logic [63:0]  plain_enc;
    logic [63:0]  base;
    logic [63:0]  power;
    pe_pkg::key_t e;
    if (modulus_n < 2) return '0;
    plain_enc = (64'(modulus_n) * 64'(m) + 64'd1) % modulus_sq;
    base  = 64'(r) % modulus_sq;
    power = 64'd1;
    e     = modulus_n;
    while (e != 0) begin
      if (e[0]) power = mul_reduce(power, base, modulus_sq);
      base = mul_reduce(base, base, modulus_sq);
      e    = e >> 1;
    end
    return pe_pkg::sq_t'(mul_reduce(plain_enc, power, modulus_sq));
  endfunction

  // Monitor: sample at the rising edge, predict on each accepted request,
  // check each strobed ciphertext against the oldest prediction.
  always @(posedge clk_i) begin
    logic        progress;
    pe_pkg::sq_t want;
    progress = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        cipher_queue.push_back(encrypt_expected(plaintext_i, random_r_i));
        void'(enc_queue.pop_front());
        requests_sent++;
        progress = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        modulus_n  = cfg_data_i;
        modulus_sq = 64'(modulus_n) * 64'(modulus_n);
        key_writes++;
        progress = 1'b1;
      end
      if (done_o) begin
        progress = 1'b1;
        ciphers_seen++;
        if (cipher_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected ciphertext expected none actual %h", $time, ciphertext_o);
        end else begin
          want = cipher_queue.pop_front();
          if (ciphertext_o !== want) begin
            errors++;
            $display("%0t: ciphertext mismatch expected %h actual %h",
                     $time, want, ciphertext_o);
          end
        end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Driver: change inputs at the falling edge. Hold a request until the
  // monitor has taken it off the queue, then send the next in bursts.
  always @(negedge clk_i) begin
    logic go;
    go = 1'b0;
    if (rst_ni && enc_queue.size() != 0) begin
      if (start && enc_queue.size() != 0 && plaintext_i == enc_queue[0].plaintext
          && random_r_i == enc_queue[0].random_r && !(gap_left == 0 && burst_left == 0)) begin
        go = 1'b1;
      end
      if (!go) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            // leave some bursts with no gap at all
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
          burst_left--;
          go = 1'b1;
        end
      end
    end
    start <= go;
    if (go) begin
      plaintext_i <= enc_queue[0].plaintext;
      random_r_i  <= enc_queue[0].random_r;
    end
  end

  task automatic write_key(pe_pkg::key_t value);
    int unsigned seen;
    seen = key_writes;
    @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    while (key_writes == seen) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    // let the block rebuild n squared
    repeat (100) @(posedge clk_i);
  endtask

  task automatic queue_request(pe_pkg::key_t m, pe_pkg::key_t r);
    enc_req_t item;
    item.plaintext = m;
    item.random_r  = r;
    enc_queue.push_back(item);
  endtask

  task automatic drain;
    while (enc_queue.size() != 0 || cipher_queue.size() != 0 || busy) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Mostly well-formed requests (m < n, 1 <= r < n), some raw full-range noise.
  task automatic random_phase(pe_pkg::key_t n, int unsigned count);
    pe_pkg::key_t m;
    pe_pkg::key_t r;
    for (int unsigned i = 0; i < count; i++) begin
      if (n >= 3 && $urandom_range(0, 4) != 0) begin
        m = pe_pkg::key_t'($urandom_range(0, n - 1));
        r = pe_pkg::key_t'($urandom_range(1, n - 1));
      end else begin
        m = pe_pkg::key_t'($urandom);
        r = pe_pkg::key_t'($urandom);
      end
      queue_request(m, r);
    end
  endtask

  initial begin
    pe_pkg::key_t nbound;
    pe_pkg::key_t n;
    modulus_n  = 3;
    modulus_sq = 64'd9;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset key n = 3: r above n squared, m above n
    queue_request(0, 1);
    queue_request(2, 20);
    queue_request(KeyMax, KeyMax);
    drain();

    // largest key: field extremes and the negative-range edges
    write_key(KeyMax);
    nbound = KeyMax / 3 - 1;
    queue_request(0, 1);
    queue_request(KeyMax - 1, KeyMax - 1);
    queue_request(KeyMax, KeyMax);
    queue_request(KeyMax - nbound, 12345);
    queue_request(KeyMax - nbound - 1, 777);
    queue_request(12345, 0);
    queue_request(31'h2AAA_AAAA, 31'h5555_5555);
    drain();

    // small moduli: empty negative range, zero ciphertext for n below 2
    write_key(0);
    queue_request(5, 3);
    drain();
    write_key(1);
    queue_request(0, 1);
    drain();
    write_key(2);
    queue_request(1, 1);
    queue_request(3, 7);
    drain();

    // small composite key: plaintext above n, r above n squared, zero r
    write_key(15);
    queue_request(100, 1000);
    queue_request(14, 14);
    queue_request(10, 4);
    queue_request(4, 0);
    drain();

    // random keys, mostly short, a few full width
    for (int p = 0; p < 7; p++) begin
      if (p % 3 == 2) n = pe_pkg::key_t'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
      else            n = pe_pkg::key_t'($urandom_range(3, 32'h0000_FFFF));
      write_key(n);
      random_phase(n, 17);
      drain();
    end

    write_key(3);
    random_phase(3, 4);
    drain();

    repeat (100) @(posedge clk_i);
    $display("Covered %0d encryptions over %0d key settings, n from 0 to 2^31-1.",
             requests_sent, key_writes);
    $display("Saw %0d ciphertexts, %0d mismatches.", ciphers_seen, errors);
    if (errors == 0 && cipher_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
